@@ design/ioi_histogram_tempo_estimator_core_defines.svh @@
// Assertion macros for the tempo estimator core
`ifndef IOI_HISTOGRAM_TEMPO_ESTIMATOR_CORE_DEFINES_SVH
`define IOI_HISTOGRAM_TEMPO_ESTIMATOR_CORE_DEFINES_SVH

// same-cycle implication
`define HTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hte assertion failed");

// next-cycle implication
`define HTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hte assertion failed");

`endif

@@ design/hte_pkg.sv @@
// Shared constants and types for the tempo estimator
package hte_pkg;
  localparam int RingDepthDef = 64;
  localparam int HistBinsDef  = 256;
  localparam int IntervalW    = 10;
  localparam int SumPrevW     = 5;
  localparam int HistoSizeW   = 9;
  localparam int TempoW       = 8;
  localparam int MinSum       = 20;
  localparam int FirstBin     = 5;
  localparam logic [SumPrevW-1:0]   SumPrevRst   = 5'd5;
  localparam logic [HistoSizeW-1:0] HistoSizeRst = 9'd200;

  typedef enum logic {CmdAdd = 1'b0, CmdEstimate = 1'b1} cmd_e;
  typedef enum logic {RegSumPrev = 1'b0, RegHistoSize = 1'b1} reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_BRD, ST_BADD, ST_BINC, ST_BNEXT,
    ST_WHK, ST_WHKD, ST_WTAP, ST_WF, ST_WF1, ST_WMUL, ST_WCMP, ST_DONE
  } state_e;
endpackage

@@ design/hte_ram.sv @@
// Generic single write port RAM with registered read
module hte_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ design/ioi_histogram_tempo_estimator_core.sv @@
// Tempo estimator: interval ring, sum histogram build and weighted argmax sequencer
// An add transfer (cmd 0) stores the interval in the ring. An estimate transfer
// (cmd 1) runs a sequencer over two RAMs, each with one write port and one
// registered read port. ST_CLR clears all HIST_BINS histogram bins. Each windowed
// sum step then passes ST_BRD, ST_BADD and ST_BNEXT, plus ST_BINC when the sum
// lands in range. There are n * min(sum_previous, n-1) steps, each with one ring
// read and at most one histogram read-modify-write. Each bin from 5 to min(histo_size,
// HIST_BINS)-1 passes ST_WHK, ST_WHKD, its taps (ST_WTAP, plus ST_WF and ST_WF1 as
// needed), ST_WMUL and ST_WCMP; all histogram reads use the one read port. The
// result waits in ST_DONE for any earlier one; the input stalls for the whole estimate.
module ioi_histogram_tempo_estimator_core #(
  parameter int RING_DEPTH = hte_pkg::RingDepthDef,
  parameter int HIST_BINS  = hte_pkg::HistBinsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [hte_pkg::IntervalW-1:0]  interval_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hte_pkg::TempoW-1:0]     tempo_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  `include "ioi_histogram_tempo_estimator_core_defines.svh"

  localparam int RaW   = $clog2(RING_DEPTH);
  localparam int CntRW = $clog2(RING_DEPTH + 1);
  localparam int HaW   = $clog2(HIST_BINS);
  localparam int HsW   = $clog2(HIST_BINS + 1);
  localparam int CntW  = $clog2(RING_DEPTH * 32) + 1;
  localparam int SumW  = hte_pkg::IntervalW + hte_pkg::SumPrevW;
  localparam int QW    = HsW + 3;
  localparam int AccW  = CntW + 5;
  localparam int WW    = AccW + CntW;
  localparam int SpW   = hte_pkg::SumPrevW;

  hte_pkg::state_e state_q, state_d;
  logic [SpW-1:0]                 sum_prev_q;
  logic [hte_pkg::HistoSizeW-1:0] histo_size_q;
  logic [RaW-1:0]   wp_q, wp_d, p_q, p_d, idx_q, idx_d;
  logic [CntRW-1:0] n_q, n_d;
  logic [HsW-1:0]   hs_q, hs_d, k_q, k_d, tempo_q, tempo_d;
  logic [SpW-1:0]   win_q, win_d, j_q, j_d;
  logic [SumW-1:0]  s_q, s_d;
  logic [HaW-1:0]   clr_q, clr_d;
  logic [1:0]       t_q, t_d;
  logic [CntW-1:0]  hk_q, hk_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [WW-1:0]    w_q, w_d, best_q, best_d;
  logic             out_valid_q, out_valid_d;
  logic [hte_pkg::TempoW-1:0] tempo_out_q, tempo_out_d;

  logic                          ring_we;
  logic [RaW-1:0]                ring_waddr;
  logic [hte_pkg::IntervalW-1:0] ring_rdata;
  logic                          hist_we;
  logic [HaW-1:0]                hist_waddr, hist_raddr;
  logic [CntW-1:0]               hist_wdata, hist_rdata;

  logic            in_acc, cfg_we;
  logic [QW-1:0]   q, lim;
  logic [1:0]      r;
  logic [QW-3:0]   f;
  logic [SumW-1:0] s_add;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != hte_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign tempo_o = tempo_out_q;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == hte_pkg::RegHistoSize) ? 32'(histo_size_q) : 32'(sum_prev_q);

  assign q     = QW'(k_q) << t_q;
  assign lim   = (QW'(hs_q) - QW'(1)) << 2;
  assign r     = q[1:0];
  assign f     = q[QW-1:2];
  assign s_add = s_q + SumW'(ring_rdata);

  hte_ram #(.Width(hte_pkg::IntervalW), .Depth(RING_DEPTH)) u_ring (
    .clk_i, .we_i(ring_we), .waddr_i(ring_waddr), .wdata_i(interval_i),
    .raddr_i(idx_q), .rdata_o(ring_rdata)
  );

  hte_ram #(.Width(CntW), .Depth(HIST_BINS)) u_hist (
    .clk_i, .we_i(hist_we), .waddr_i(hist_waddr), .wdata_i(hist_wdata),
    .raddr_i(hist_raddr), .rdata_o(hist_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hte_pkg::ST_IDLE;
      sum_prev_q   <= hte_pkg::SumPrevRst;
      histo_size_q <= hte_pkg::HistoSizeRst;
      wp_q         <= RaW'(RING_DEPTH - 1);
      n_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (cfg_we && paddr[2] == hte_pkg::RegSumPrev) begin
        sum_prev_q <= pwdata[SpW-1:0];
      end
      if (cfg_we && paddr[2] == hte_pkg::RegHistoSize) begin
        histo_size_q <= pwdata[hte_pkg::HistoSizeW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; idx_q <= idx_d; hs_q <= hs_d; k_q <= k_d; tempo_q <= tempo_d;
    win_q <= win_d; j_q <= j_d; s_q <= s_d; clr_q <= clr_d; t_q <= t_d;
    hk_q <= hk_d; acc_q <= acc_d; w_q <= w_d; best_q <= best_d;
    tempo_out_q <= tempo_out_d;
  end

  always_comb begin
    state_d = state_q;
    wp_d = wp_q; n_d = n_q; p_d = p_q; idx_d = idx_q; hs_d = hs_q; k_d = k_q;
    tempo_d = tempo_q; win_d = win_q; j_d = j_q; s_d = s_q; clr_d = clr_q;
    t_d = t_q; hk_d = hk_q; acc_d = acc_q; w_d = w_q; best_d = best_q;
    tempo_out_d = tempo_out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ring_we = 1'b0; ring_waddr = wp_q;
    hist_we = 1'b0; hist_waddr = clr_q; hist_wdata = '0; hist_raddr = HaW'(k_q);
    case (state_q)
      hte_pkg::ST_IDLE: begin
        if (in_acc && cmd_i == hte_pkg::CmdAdd) begin
          wp_d = (wp_q == RaW'(RING_DEPTH - 1)) ? '0 : wp_q + RaW'(1);
          ring_we = 1'b1;
          ring_waddr = wp_d;
          if (n_q != CntRW'(RING_DEPTH)) n_d = n_q + CntRW'(1);
        end else if (in_acc) begin
          hs_d = ({2'b0, histo_size_q} > 11'(HIST_BINS)) ? HsW'(HIST_BINS)
                                                       : HsW'(histo_size_q);
          if (n_q < CntRW'(2)) win_d = '0;
          else if (12'(sum_prev_q) > 12'(n_q) - 12'd1) win_d = SpW'(n_q - CntRW'(1));
          else win_d = sum_prev_q;
          clr_d = '0;
          state_d = hte_pkg::ST_CLR;
        end
      end
      hte_pkg::ST_CLR: begin
        hist_we = 1'b1;
        clr_d = clr_q + HaW'(1);
        p_d = '0; idx_d = '0; j_d = '0; s_d = '0;
        k_d = HsW'(hte_pkg::FirstBin); best_d = '0; tempo_d = '0;
        if (clr_q == HaW'(HIST_BINS - 1)) begin
          if (win_q != '0) state_d = hte_pkg::ST_BRD;
          else if (hs_q > HsW'(hte_pkg::FirstBin)) state_d = hte_pkg::ST_WHK;
          else state_d = hte_pkg::ST_DONE;
        end
      end
      hte_pkg::ST_BRD: state_d = hte_pkg::ST_BADD;
      hte_pkg::ST_BADD: begin
        s_d = s_add;
        hist_raddr = s_add[HaW-1:0];
        if (s_add > SumW'(hte_pkg::MinSum) && s_add < SumW'(hs_q)) state_d = hte_pkg::ST_BINC;
        else state_d = hte_pkg::ST_BNEXT;
      end
      hte_pkg::ST_BINC: begin
        hist_we = 1'b1;
        hist_waddr = s_q[HaW-1:0];
        hist_wdata = hist_rdata + CntW'(1);
        state_d = hte_pkg::ST_BNEXT;
      end
      hte_pkg::ST_BNEXT: begin
        state_d = hte_pkg::ST_BRD;
        if (j_q == win_q - SpW'(1)) begin
          j_d = '0; s_d = '0;
          if (CntRW'(p_q) == n_q - CntRW'(1)) begin
            state_d = (hs_q > HsW'(hte_pkg::FirstBin)) ? hte_pkg::ST_WHK : hte_pkg::ST_DONE;
          end else begin
            p_d = p_q + RaW'(1);
            idx_d = p_q + RaW'(1);
          end
        end else begin
          j_d = j_q + SpW'(1);
          idx_d = (idx_q == '0) ? RaW'(n_q - CntRW'(1)) : idx_q - RaW'(1);
        end
      end
      hte_pkg::ST_WHK: state_d = hte_pkg::ST_WHKD;
      hte_pkg::ST_WHKD: begin
        hk_d = hist_rdata; acc_d = '0; t_d = '0;
        state_d = hte_pkg::ST_WTAP;
      end
      hte_pkg::ST_WTAP: begin
        hist_raddr = HaW'(f);
        if (q < QW'(hte_pkg::MinSum) || q >= lim) begin
          t_d = t_q + 2'd1;
          if (t_q == 2'd3) state_d = hte_pkg::ST_WMUL;
        end else begin
          state_d = hte_pkg::ST_WF;
        end
      end
      hte_pkg::ST_WF: begin
        hist_raddr = HaW'(f) + HaW'(1);
        acc_d = acc_q + AccW'(hist_rdata) * AccW'(3'd4 - {1'b0, r});
        if (r != 2'd0) state_d = hte_pkg::ST_WF1;
        else begin
          t_d = t_q + 2'd1;
          state_d = (t_q == 2'd3) ? hte_pkg::ST_WMUL : hte_pkg::ST_WTAP;
        end
      end
      hte_pkg::ST_WF1: begin
        acc_d = acc_q + AccW'(hist_rdata) * AccW'(r);
        t_d = t_q + 2'd1;
        state_d = (t_q == 2'd3) ? hte_pkg::ST_WMUL : hte_pkg::ST_WTAP;
      end
      hte_pkg::ST_WMUL: begin
        w_d = WW'(acc_q) * WW'(hk_q);
        state_d = hte_pkg::ST_WCMP;
      end
      hte_pkg::ST_WCMP: begin
        if (w_q > best_q) begin
          best_d = w_q;
          tempo_d = k_q;
        end
        k_d = k_q + HsW'(1);
        state_d = (k_q == hs_q - HsW'(1)) ? hte_pkg::ST_DONE : hte_pkg::ST_WHK;
      end
      hte_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          tempo_out_d = (tempo_q == '0) ? hte_pkg::TempoW'(1) : tempo_q[hte_pkg::TempoW-1:0];
          state_d = hte_pkg::ST_IDLE;
        end
      end
      default: state_d = hte_pkg::ST_IDLE;
    endcase
  end

  `HTE_ASSERT_NOW(a_tempo_nonzero, out_valid_o, tempo_o != '0)
  `HTE_ASSERT_NOW(a_count_bound, 1'b1, n_q <= CntRW'(RING_DEPTH))
  `HTE_ASSERT_NEXT(a_estimate_busy, in_acc && cmd_i == hte_pkg::CmdEstimate, in_stall_o)
  `HTE_ASSERT_NEXT(a_add_no_busy, in_acc && cmd_i == hte_pkg::CmdAdd, !in_stall_o)
endmodule
